// ===== rtl/ism_pkg.sv =====
// Shared types and constants for the interval subscription matcher.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package ism_pkg;

    localparam int SUB_ID_W  = 6;
    localparam int ATTR_W    = 4;
    localparam int FIELD_V_W = 16;
    localparam int SET_W     = 64;
    localparam int COUNT_W   = 7;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_PAIR   = 1'b1;

    typedef struct packed {
        logic                 op;
        logic [SUB_ID_W-1:0]  sub_id;
        logic [ATTR_W-1:0]    attribute;
        logic [FIELD_V_W-1:0] low_bound;
        logic [FIELD_V_W-1:0] high_bound;
        logic [FIELD_V_W-1:0] pub_value;
        logic                 last_pair;
    } item_t;

    typedef struct packed {
        logic [SET_W-1:0]   matched_set;
        logic [COUNT_W-1:0] match_count;
    } result_t;

    typedef enum logic {
        KIND_INSERT,
        KIND_PAIR
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic                 attr_ok;
        logic [SUB_ID_W-1:0]  sub_id;
        logic [ATTR_W-1:0]    attribute;
        logic [FIELD_V_W-1:0] low_bound;
        logic [FIELD_V_W-1:0] high_bound;
        logic [FIELD_V_W-1:0] pub_value;
        logic                 last_pair;
    } work_t;

    typedef struct packed {
        logic take;
        logic init_busy;
    } back_status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INS_RD,
        ST_INS_WR,
        ST_SWEEP,
        ST_TAIL,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/ism_front.sv =====
// Front end: accepts items, classifies them and holds them in a two-entry queue.
// Depends on ism_pkg.
`default_nettype none

module ism_front #(
    parameter int NUM_SUBS  = 64,
    parameter int NUM_ATTRS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire ism_pkg::item_t        item,
    output logic                       q_valid,
    output ism_pkg::work_t             q_item,
    input  wire ism_pkg::back_status_t bstat
);

    ism_pkg::work_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    ism_pkg::work_t cls;
    logic           sub_ok;
    logic           keep;
    logic           wr_en;
    logic           rd_en;

    always_comb
    begin
        sub_ok        = 32'(item.sub_id) < NUM_SUBS;
        cls.attr_ok   = 32'(item.attribute) < NUM_ATTRS;
        cls.kind      = (item.op == ism_pkg::OP_PAIR) ? ism_pkg::KIND_PAIR
                                                      : ism_pkg::KIND_INSERT;
        cls.sub_id     = item.sub_id;
        cls.attribute  = item.attribute;
        cls.low_bound  = item.low_bound;
        cls.high_bound = item.high_bound;
        cls.pub_value  = item.pub_value;
        cls.last_pair  = item.last_pair;
        // out-of-range inserts are dropped here
        keep = (item.op == ism_pkg::OP_PAIR) || (sub_ok && cls.attr_ok);
    end

    assign full    = (count_reg == 2'd2) || bstat.init_busy;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign wr_en   = push && !full && keep;
    assign rd_en   = bstat.take && q_valid;

    always_comb
    begin
        count_next = count_reg;
        case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_en)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ism_back.sv =====
// Back end: constraint store, insert read-modify-write, per-pair sweep
// over all subscriptions, miss marks and the result register. Depends on ism_pkg.
`default_nettype none

module ism_back #(
    parameter int NUM_SUBS   = 64,
    parameter int NUM_ATTRS  = 16,
    parameter int VALUE_BITS = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    input  wire ism_pkg::work_t  q_item,
    output ism_pkg::back_status_t bstat,
    input  wire logic            pop,
    output logic                 empty,
    output ism_pkg::result_t     result
);

    localparam int SUB_AW  = $clog2(NUM_SUBS);
    localparam int ATTR_AW = (NUM_ATTRS > 1) ? $clog2(NUM_ATTRS) : 1;
    localparam int AW      = SUB_AW + ATTR_AW;
    localparam int DEPTH   = 1 << AW;
    localparam int WORD_W  = 1 + 2 * VALUE_BITS;

    function automatic logic [VALUE_BITS-1:0] to_val(input logic [ism_pkg::FIELD_V_W-1:0] x);
        logic [VALUE_BITS+ism_pkg::FIELD_V_W-1:0] w;
        w = {{VALUE_BITS{1'b0}}, x};
        return w[VALUE_BITS-1:0];
    endfunction

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    ism_pkg::state_t state_reg;
    ism_pkg::state_t state_next;

    ism_pkg::work_t      cur_reg;
    logic [AW-1:0]       clr_addr_reg;
    logic [SUB_AW-1:0]   s_reg;
    logic                cmp_valid_reg;
    logic [SUB_AW-1:0]   cmp_sub_reg;
    logic [NUM_SUBS-1:0] present_reg;
    logic [NUM_SUBS-1:0] marks_reg;
    logic [NUM_SUBS-1:0] set_reg;
    logic [ism_pkg::COUNT_W-1:0] cnt_reg;
    logic                out_valid_reg;
    ism_pkg::result_t    out_reg;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [WORD_W-1:0]     mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic                  take;
    logic                  load_out;

    logic [ATTR_AW+ism_pkg::ATTR_W-1:0] attr_wide;
    logic [ATTR_AW-1:0]    attr_idx;
    logic [SUB_AW-1:0]     sub_idx;
    logic [AW-1:0]         cur_addr;
    logic                  r_flag;
    logic [VALUE_BITS-1:0] r_lo;
    logic [VALUE_BITS-1:0] r_hi;
    logic [VALUE_BITS-1:0] in_lo;
    logic [VALUE_BITS-1:0] in_hi;
    logic [VALUE_BITS-1:0] new_lo;
    logic [VALUE_BITS-1:0] new_hi;
    logic [VALUE_BITS-1:0] pval;
    logic                  hit;
    logic                  new_mark;
    logic                  keep_bit;

    always_comb
    begin
        attr_wide = {{ATTR_AW{1'b0}}, cur_reg.attribute};
        attr_idx  = attr_wide[ATTR_AW-1:0];
        sub_idx   = cur_reg.sub_id[SUB_AW-1:0];
        cur_addr  = {sub_idx, attr_idx};
        r_flag    = rdata_reg[WORD_W-1];
        r_lo      = rdata_reg[2*VALUE_BITS-1:VALUE_BITS];
        r_hi      = rdata_reg[VALUE_BITS-1:0];
        in_lo     = to_val(cur_reg.low_bound);
        in_hi     = to_val(cur_reg.high_bound);
        pval      = to_val(cur_reg.pub_value);
        // intersection with an existing interval
        new_lo    = (r_flag && (r_lo > in_lo)) ? r_lo : in_lo;
        new_hi    = (r_flag && (r_hi < in_hi)) ? r_hi : in_hi;
        hit       = cmp_valid_reg && cur_reg.attr_ok && r_flag
                    && ((pval < r_lo) || (pval > r_hi));
        new_mark  = marks_reg[cmp_sub_reg] || hit;
        keep_bit  = present_reg[cmp_sub_reg] && !new_mark;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ism_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == {AW{1'b1}})
                begin
                    state_next = ism_pkg::ST_IDLE;
                end
            end
            ism_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (q_item.kind == ism_pkg::KIND_INSERT) ? ism_pkg::ST_INS_RD
                                                                      : ism_pkg::ST_SWEEP;
                end
            end
            ism_pkg::ST_INS_RD: state_next = ism_pkg::ST_INS_WR;
            ism_pkg::ST_INS_WR: state_next = ism_pkg::ST_IDLE;
            ism_pkg::ST_SWEEP:
            begin
                if (s_reg == SUB_AW'(NUM_SUBS - 1))
                begin
                    state_next = ism_pkg::ST_TAIL;
                end
            end
            ism_pkg::ST_TAIL:
            begin
                state_next = cur_reg.last_pair ? ism_pkg::ST_EMIT : ism_pkg::ST_IDLE;
            end
            ism_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || pop)
                begin
                    state_next = ism_pkg::ST_IDLE;
                end
            end
            default: state_next = ism_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cur_addr;
        mem_wdata = {1'b1, new_lo, new_hi};
        mem_raddr = cur_addr;
        take      = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            ism_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
            end
            ism_pkg::ST_IDLE:   take = q_valid;
            ism_pkg::ST_INS_WR: mem_we = 1'b1;
            ism_pkg::ST_SWEEP:  mem_raddr = {s_reg, attr_idx};
            ism_pkg::ST_EMIT:   load_out = !out_valid_reg || pop;
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign bstat.take      = take;
    assign bstat.init_busy = (state_reg == ism_pkg::ST_CLEAR);
    assign empty           = !out_valid_reg;
    assign result          = out_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ism_pkg::ST_CLEAR;
            cur_reg       <= '0;
            clr_addr_reg  <= '0;
            s_reg         <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_sub_reg   <= '0;
            present_reg   <= '0;
            marks_reg     <= '0;
            set_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= (state_reg == ism_pkg::ST_SWEEP);
            cmp_sub_reg   <= s_reg;
            if (state_reg == ism_pkg::ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (take)
            begin
                cur_reg <= q_item;
                s_reg   <= '0;
                set_reg <= '0;
                cnt_reg <= '0;
            end
            if (state_reg == ism_pkg::ST_SWEEP)
            begin
                s_reg <= s_reg + SUB_AW'(1);
            end
            if (state_reg == ism_pkg::ST_INS_WR)
            begin
                present_reg[sub_idx] <= 1'b1;
            end
            if (cmp_valid_reg)
            begin
                marks_reg[cmp_sub_reg] <= new_mark;
                set_reg[cmp_sub_reg]   <= keep_bit;
                cnt_reg                <= cnt_reg + ism_pkg::COUNT_W'(keep_bit);
            end
            if (load_out)
            begin
                out_valid_reg       <= 1'b1;
                out_reg.matched_set <= ism_pkg::SET_W'(set_reg);
                out_reg.match_count <= cnt_reg;
                marks_reg           <= '0;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/interval_subscription_matcher.sv =====
// Top level of the interval subscription matcher: front queue and back engine.
// Depends on ism_pkg, ism_front and ism_back.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------
//   items    | push / full        | item   (ism_pkg::item_t)
//   results  | empty / pop        | result (ism_pkg::result_t)
//
// Insert: take, store read, then write of the intersected interval.
// Publication pair: take, a sweep of one store entry per subscription per cycle
// on the single read port, and a tail step; after the last pair an emit step loads
// the result register, waiting while the previous result is still unread. After
// reset a clearing pass writes all store entries (1024 by default), full held high.
// Two items queue in front; one result waits in the output register.
`default_nettype none

module interval_subscription_matcher #(
    parameter int NUM_SUBS   = 64,
    parameter int NUM_ATTRS  = 16,
    parameter int VALUE_BITS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire ism_pkg::item_t   item,
    output logic                  empty,
    input  wire logic             pop,
    output ism_pkg::result_t      result
);

    logic                  q_valid;
    ism_pkg::work_t        q_item;
    ism_pkg::back_status_t bstat;

    ism_front #(
        .NUM_SUBS  (NUM_SUBS),
        .NUM_ATTRS (NUM_ATTRS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .q_valid (q_valid),
        .q_item  (q_item),
        .bstat   (bstat)
    );

    ism_back #(
        .NUM_SUBS   (NUM_SUBS),
        .NUM_ATTRS  (NUM_ATTRS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .bstat   (bstat),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

`default_nettype wire

// ===== rtl/ism_checker.sv =====
// Port-level checks for the interval subscription matcher, bound to the top level.
// Depends on ism_pkg and interval_subscription_matcher.
`default_nettype none

module ism_checker #(
    parameter int NUM_SUBS = 64
) (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             full,
    input wire logic             pop,
    input wire logic             empty,
    input wire ism_pkg::result_t result
);

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("waiting result changed or vanished");

    a_count_matches_set: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> $countones(result.matched_set) == 32'(result.match_count))
        else $error("match_count disagrees with matched_set");

    a_set_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.matched_set >> NUM_SUBS) == '0)
        else $error("matched_set names a subscription out of range");

    a_full_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> full)
        else $error("items accepted during the clearing pass");

endmodule

bind interval_subscription_matcher ism_checker #(
    .NUM_SUBS (NUM_SUBS)
) u_ism_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .full   (full),
    .pop    (pop),
    .empty  (empty),
    .result (result)
);

`default_nettype wire
